// File: rtl/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared widths, constants, tables and helpers of the great-circle distance
// pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

    // Number of CORDIC micro-rotations, in both rotation and vectoring mode.
    localparam int CORDIC_ITERATIONS = 32;
    localparam int TABLE_LEN         = 48;

    // Datapath widths.
    localparam int LAT_W   = 25;
    localparam int LNG_W   = 26;
    localparam int MAG_W   = 26;
    localparam int PHASE_W = 32;
    localparam int XY_W    = 34;
    localparam int Q30_W   = 31;
    localparam int RAD_W   = 33;
    localparam int DIST_W  = 32;
    localparam int SQ_W    = 61;
    localparam int SQRT_STEPS = 31;

    // Coordinate limits in units of 1e-5 degree.
    localparam logic signed [LAT_W-1:0] LAT_MAX = 25'sd9000000;
    localparam logic signed [LNG_W-1:0] LNG_MAX = 26'sd18000000;

    // One turn is 360 degrees in input units.
    localparam logic [MAG_W-1:0] UNITS_PER_TURN = 26'd36000000;

    // Phase conversion by reciprocal multiplication. The reciprocal is
    // ceil(2^83 / one turn); with 52 fraction bits the error stays below
    // one part in a turn for every magnitude under 2^26, so the floor is
    // exact. Half a turn maps to exactly one half in the fraction.
    localparam int PHASE_FRAC = 52;
    localparam logic [83:0] PHASE_RECIP_WIDE =
        ((84'd1 << 83) + 84'(UNITS_PER_TURN) - 84'd1) / 84'(UNITS_PER_TURN);
    localparam logic [57:0] PHASE_RECIP = PHASE_RECIP_WIDE[57:0];
    localparam logic [83:0] PHASE_ROUND = 84'd1 << (PHASE_FRAC - 1);

    localparam logic signed [XY_W-1:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [XY_W-1:0] ONE_Q30  = 34'sd1073741824;
    localparam logic signed [XY_W-1:0] HALF_TURN_Q31 = 34'sd2147483648;

    // round(0.4 * pi * 2^30) and the reset radius in millimeters.
    localparam logic [30:0]      FOUR_PI_TENTH = 31'd1349303771;
    localparam logic [RAD_W-1:0] RADIUS_RESET  = 33'd6372797561;

    // round(atan(2^-i) * 2^32 / (2*pi)).
    localparam logic [29:0] ATAN_TURN [0:TABLE_LEN-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
        30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
        30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304,
        30'd652, 30'd326, 30'd163, 30'd81,
        30'd41, 30'd20, 30'd10, 30'd5,
        30'd3, 30'd1, 30'd1, 30'd0,
        30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0,
        30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0
    };

    // Q30 product, rounded by adding one half and flooring.
    function automatic logic signed [XY_W-1:0] mul_q30(
        input logic signed [XY_W-1:0] a,
        input logic signed [XY_W-1:0] b
    );
        logic signed [2*XY_W-1:0] p;
        p = a * b;
        p = p + 68'sd536870912;
        return p[XY_W+29:30];
    endfunction

endpackage

// File: rtl/gcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_if
// Valid/ready channels: point pairs in, distances out.
// ----------------------------------------------------------------------------
interface gcd_pt_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [gcd_pkg::LAT_W-1:0]      point_a_lat;
    logic signed [gcd_pkg::LNG_W-1:0]      point_a_lng;
    logic signed [gcd_pkg::LAT_W-1:0]      point_b_lat;
    logic signed [gcd_pkg::LNG_W-1:0]      point_b_lng;

    modport source (output valid, point_a_lat, point_a_lng, point_b_lat, point_b_lng,
                    input ready);
    modport sink   (input valid, point_a_lat, point_a_lng, point_b_lat, point_b_lng,
                    output ready);
endinterface

interface gcd_dist_if;
    logic                          valid;
    logic                          ready;
    logic [gcd_pkg::DIST_W-1:0]    distance_cm;

    modport source (output valid, distance_cm, input ready);
    modport sink   (input valid, distance_cm, output ready);
endinterface

// File: rtl/great_circle_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance
// Haversine distance between two points in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one pair of points per clock, unless the output stalls, and
// returns one distance in centimeters per pair, in order. The stages are one
// input stage, a three-stage phase conversion by reciprocal multiplication,
// the sine/cosine CORDIC, three multiply stages, a 31-stage square root, the
// arctangent CORDIC and three scaling stages; the CORDICs take one stage per
// micro-rotation and the square root one stage per result bit. The pipeline
// advances whenever the output register is empty or being taken, so a stall on
// the output holds every stage in place. The radius register may be written
// only while the pipeline is empty.
// ----------------------------------------------------------------------------
module great_circle_distance (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [gcd_pkg::RAD_W-1:0]       i_cfg_wr_data,
    gcd_pt_if.sink                          i_pt,
    gcd_dist_if.source                      o_dist
);
    localparam int MW = gcd_pkg::MAG_W;
    localparam int W  = gcd_pkg::XY_W;
    localparam int QW = gcd_pkg::Q30_W;

    logic                     w_adv;
    logic [gcd_pkg::RAD_W-1:0] r_radius;

    logic signed [gcd_pkg::LAT_W-1:0] w_lat_a, w_lat_b;
    logic signed [gcd_pkg::LNG_W-1:0] w_lng_a, w_lng_b;
    logic signed [MW:0]               w_dlat, w_dlng;

    logic                 r_s0_vld;
    logic [3:0][MW-1:0]   r_s0_mag;
    logic [3:0]           r_s0_neg;

    logic [3:0][gcd_pkg::PHASE_W-1:0] w_phase;
    logic                             w_div_vld;
    logic                             w_rot_vld;
    logic signed [W-1:0]              w_sin_lat, w_sin_lng, w_cos_a, w_cos_b;

    logic                r_m1_vld, r_m2_vld, r_m3_vld;
    logic signed [W-1:0] r_lat_h, r_lng_h, r_cc, r_lat_h2, r_t;
    logic signed [W:0]   w_h_sum;
    logic [QW-1:0]       r_h;
    logic [gcd_pkg::SQ_W-1:0] w_sq_c, w_sq_h;

    logic          w_sq_vld;
    logic [QW-1:0] w_root_c, w_root_h;
    logic          w_vec_vld;
    logic [QW-1:0] w_angle;

    logic        r_f1_vld, r_f2_vld, r_out_vld;
    logic [63:0] r_p;
    logic [62:0] r_lo;
    logic [63:0] r_hm;
    logic [63:0] w_hi;
    logic [33:0] w_cm;
    logic [gcd_pkg::DIST_W-1:0] r_out_cm;

    // Whole pipeline moves when the output register can take a word.
    assign w_adv      = !r_out_vld || o_dist.ready;
    assign i_pt.ready = w_adv;

    // Radius register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= gcd_pkg::RADIUS_RESET;
        end else if (i_cfg_wr_en) begin
            r_radius <= i_cfg_wr_data;
        end
    end

    // Saturate the coordinates and form the differences.
    always_comb begin
        w_lat_a = i_pt.point_a_lat;
        w_lat_b = i_pt.point_b_lat;
        w_lng_a = i_pt.point_a_lng;
        w_lng_b = i_pt.point_b_lng;
        if (w_lat_a > gcd_pkg::LAT_MAX) w_lat_a = gcd_pkg::LAT_MAX;
        if (w_lat_a < -gcd_pkg::LAT_MAX) w_lat_a = -gcd_pkg::LAT_MAX;
        if (w_lat_b > gcd_pkg::LAT_MAX) w_lat_b = gcd_pkg::LAT_MAX;
        if (w_lat_b < -gcd_pkg::LAT_MAX) w_lat_b = -gcd_pkg::LAT_MAX;
        if (w_lng_a > gcd_pkg::LNG_MAX) w_lng_a = gcd_pkg::LNG_MAX;
        if (w_lng_a < -gcd_pkg::LNG_MAX) w_lng_a = -gcd_pkg::LNG_MAX;
        if (w_lng_b > gcd_pkg::LNG_MAX) w_lng_b = gcd_pkg::LNG_MAX;
        if (w_lng_b < -gcd_pkg::LNG_MAX) w_lng_b = -gcd_pkg::LNG_MAX;
        w_dlat = (MW+1)'(w_lat_a) - (MW+1)'(w_lat_b);
        w_dlng = (MW+1)'(w_lng_a) - (MW+1)'(w_lng_b);
    end

    // Input stage: magnitudes and signs of the four angles.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_adv) begin
            r_s0_vld <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_neg[0] <= w_dlat < 0;
            r_s0_mag[0] <= (w_dlat < 0) ? MW'(-w_dlat) : MW'(w_dlat);
            r_s0_neg[1] <= w_dlng < 0;
            r_s0_mag[1] <= (w_dlng < 0) ? MW'(-w_dlng) : MW'(w_dlng);
            r_s0_neg[2] <= w_lat_a < 0;
            r_s0_mag[2] <= (w_lat_a < 0) ? MW'(-w_lat_a) : MW'(w_lat_a);
            r_s0_neg[3] <= w_lat_b < 0;
            r_s0_mag[3] <= (w_lat_b < 0) ? MW'(-w_lat_b) : MW'(w_lat_b);
        end
    end

    // Differences are half angles; the latitudes themselves are full angles.
    gcd_phase_div u_div_dlat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_vld(r_s0_vld),
        .i_mag(r_s0_mag[0]), .i_neg(r_s0_neg[0]), .i_shift32(1'b0),
        .o_vld(w_div_vld), .o_phase(w_phase[0])
    );
    gcd_phase_div u_div_dlng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_vld(r_s0_vld),
        .i_mag(r_s0_mag[1]), .i_neg(r_s0_neg[1]), .i_shift32(1'b0),
        .o_vld(), .o_phase(w_phase[1])
    );
    gcd_phase_div u_div_lat_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_vld(r_s0_vld),
        .i_mag(r_s0_mag[2]), .i_neg(r_s0_neg[2]), .i_shift32(1'b1),
        .o_vld(), .o_phase(w_phase[2])
    );
    gcd_phase_div u_div_lat_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_vld(r_s0_vld),
        .i_mag(r_s0_mag[3]), .i_neg(r_s0_neg[3]), .i_shift32(1'b1),
        .o_vld(), .o_phase(w_phase[3])
    );

    gcd_cordic_rot u_rot_dlat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_vld(w_div_vld),
        .i_phase(w_phase[0]), .o_vld(w_rot_vld), .o_sin(w_sin_lat), .o_cos()
    );
    gcd_cordic_rot u_rot_dlng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_vld(w_div_vld),
        .i_phase(w_phase[1]), .o_vld(), .o_sin(w_sin_lng), .o_cos()
    );
    gcd_cordic_rot u_rot_lat_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_vld(w_div_vld),
        .i_phase(w_phase[2]), .o_vld(), .o_sin(), .o_cos(w_cos_a)
    );
    gcd_cordic_rot u_rot_lat_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_vld(w_div_vld),
        .i_phase(w_phase[3]), .o_vld(), .o_sin(), .o_cos(w_cos_b)
    );

    // Haversine term: squares and the cosine product, then the longitude term, then the sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_m3_vld <= 1'b0;
        end else if (w_adv) begin
            r_m1_vld <= w_rot_vld;
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= r_m2_vld;
        end
    end

    assign w_h_sum = (W+1)'(r_lat_h2) + (W+1)'(r_t);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lat_h  <= gcd_pkg::mul_q30(w_sin_lat, w_sin_lat);
            r_lng_h  <= gcd_pkg::mul_q30(w_sin_lng, w_sin_lng);
            r_cc     <= gcd_pkg::mul_q30(w_cos_a, w_cos_b);
            r_lat_h2 <= r_lat_h;
            r_t      <= gcd_pkg::mul_q30(r_cc, r_lng_h);
            // The sum is clamped between zero and one so the arcsine argument stays valid.
            if (w_h_sum < 0) begin
                r_h <= '0;
            end else if (w_h_sum > (W+1)'(gcd_pkg::ONE_Q30)) begin
                r_h <= gcd_pkg::ONE_Q30[QW-1:0];
            end else begin
                r_h <= w_h_sum[QW-1:0];
            end
        end
    end

    assign w_sq_h = {r_h, 30'd0};
    assign w_sq_c = {gcd_pkg::ONE_Q30[QW-1:0] - r_h, 30'd0};

    gcd_isqrt u_sqrt_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_vld(r_m3_vld),
        .i_val(w_sq_c), .o_vld(w_sq_vld), .o_root(w_root_c)
    );
    gcd_isqrt u_sqrt_h (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_vld(r_m3_vld),
        .i_val(w_sq_h), .o_vld(), .o_root(w_root_h)
    );

    gcd_cordic_vec u_vec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_vld(w_sq_vld),
        .i_x(w_root_c), .i_y(w_root_h), .o_vld(w_vec_vld), .o_angle(w_angle)
    );

    // Scaling: radius times angle, then times 0.4*pi split in two halves.
    assign w_hi = r_hm + {32'd0, r_lo[62:32]};
    assign w_cm = w_hi[63:30] + 34'((w_hi[29:0] >= 30'd536870912) ? 1 : 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld  <= 1'b0;
            r_f2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_f1_vld  <= w_vec_vld;
            r_f2_vld  <= r_f1_vld;
            r_out_vld <= r_f2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p  <= 64'({31'd0, r_radius} * {33'd0, w_angle});
            r_lo <= 63'({31'd0, r_p[31:0]} * {32'd0, gcd_pkg::FOUR_PI_TENTH});
            r_hm <= 64'({32'd0, r_p[63:32]} * {33'd0, gcd_pkg::FOUR_PI_TENTH});
            r_out_cm <= (w_cm[33:32] != 2'd0) ? '1 : w_cm[31:0];
        end
    end

    assign o_dist.valid       = r_out_vld;
    assign o_dist.distance_cm = r_out_cm;

endmodule

// File: rtl/gcd_phase_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_phase_div
// Three-stage conversion of an angle in 1e-5 degree units into a phase
// word, rounded to nearest, by multiplication with the reciprocal of a turn.
// ----------------------------------------------------------------------------
module gcd_phase_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_vld,
    input  logic [gcd_pkg::MAG_W-1:0]       i_mag,
    input  logic                            i_neg,
    input  logic                            i_shift32,
    output logic                            o_vld,
    output logic [gcd_pkg::PHASE_W-1:0]     o_phase
);
    localparam int MW  = gcd_pkg::MAG_W;
    localparam int PW  = gcd_pkg::PHASE_W;
    localparam int HW  = 29;
    localparam int PRW = MW + HW;
    localparam int SW  = MW + 2*HW;
    localparam int FR  = gcd_pkg::PHASE_FRAC;

    logic [MW-1:0]  w_mag;
    logic [HW-1:0]  w_recip_lo;
    logic [HW-1:0]  w_recip_hi;
    logic [SW-1:0]  w_sum;
    logic [PRW-1:0] r_p_lo;
    logic [PRW-1:0] r_p_hi;
    logic [PW-1:0]  r_q;
    logic [PW-1:0]  r_phase;
    logic           r_neg1, r_neg2;
    logic           r_vld1, r_vld2, r_vld3;

    // A full angle is twice a half angle; full-angle magnitudes never exceed
    // a quarter turn, so the doubling cannot overflow.
    assign w_mag      = i_shift32 ? {i_mag[MW-2:0], 1'b0} : i_mag;
    assign w_recip_lo = gcd_pkg::PHASE_RECIP[HW-1:0];
    assign w_recip_hi = gcd_pkg::PHASE_RECIP[2*HW-1:HW];

    // Recombine the two partial products and add the rounding half.
    assign w_sum = {r_p_hi, {HW{1'b0}}} + SW'(r_p_lo) + gcd_pkg::PHASE_ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_adv) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    // Partial products, then the quotient, then the wrap of negative angles.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p_lo  <= {{HW{1'b0}}, w_mag} * {{MW{1'b0}}, w_recip_lo};
            r_p_hi  <= {{HW{1'b0}}, w_mag} * {{MW{1'b0}}, w_recip_hi};
            r_neg1  <= i_neg;
            r_q     <= w_sum[FR+PW-1:FR];
            r_neg2  <= r_neg1;
            r_phase <= r_neg2 ? (PW'(0) - r_q) : r_q;
        end
    end

    assign o_phase = r_phase;
    assign o_vld   = r_vld3;

endmodule

// File: rtl/gcd_cordic_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_cordic_rot
// Rotation-mode CORDIC, one micro-rotation per stage, giving sine and
// cosine in Q30 of a phase word.
// ----------------------------------------------------------------------------
module gcd_cordic_rot (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_vld,
    input  logic [gcd_pkg::PHASE_W-1:0]         i_phase,
    output logic                                o_vld,
    output logic signed [gcd_pkg::XY_W-1:0]     o_sin,
    output logic signed [gcd_pkg::XY_W-1:0]     o_cos
);
    localparam int N = gcd_pkg::CORDIC_ITERATIONS;
    localparam int W = gcd_pkg::XY_W;

    logic signed [W-1:0] w_t;
    logic                w_neg;
    logic signed [W-1:0] s_x [0:N];
    logic signed [W-1:0] s_y [0:N];
    logic signed [W-1:0] s_t [0:N];
    logic                s_neg [0:N];
    logic                s_vld [0:N];
    logic signed [W-1:0] r_x [0:N-1];
    logic signed [W-1:0] r_y [0:N-1];
    logic signed [W-1:0] r_t [0:N-1];
    logic                r_neg [0:N-1];
    logic                r_vld [0:N-1];

    // Fold the phase into the right half plane, remembering a sign flip.
    always_comb begin
        w_t   = W'($signed(i_phase));
        w_neg = 1'b0;
        if (w_t > gcd_pkg::ONE_Q30) begin
            w_t   = w_t - gcd_pkg::HALF_TURN_Q31;
            w_neg = 1'b1;
        end else if (w_t < -gcd_pkg::ONE_Q30) begin
            w_t   = w_t + gcd_pkg::HALF_TURN_Q31;
            w_neg = 1'b1;
        end
    end

    assign s_x[0]   = gcd_pkg::CORDIC_K;
    assign s_y[0]   = '0;
    assign s_t[0]   = w_t;
    assign s_neg[0] = w_neg;
    assign s_vld[0] = i_vld;

    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [W-1:0] n_dx;
        logic signed [W-1:0] n_dy;
        logic signed [W-1:0] n_at;

        always_comb begin
            n_dx = s_y[i] >>> i;
            n_dy = s_x[i] >>> i;
            n_at = W'(gcd_pkg::ATAN_TURN[i]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_adv) begin
                r_vld[i] <= s_vld[i];
            end
        end

        // Rotate toward a residual angle of zero.
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (s_t[i] >= 0) begin
                    r_x[i] <= s_x[i] - n_dx;
                    r_y[i] <= s_y[i] + n_dy;
                    r_t[i] <= s_t[i] - n_at;
                end else begin
                    r_x[i] <= s_x[i] + n_dx;
                    r_y[i] <= s_y[i] - n_dy;
                    r_t[i] <= s_t[i] + n_at;
                end
                r_neg[i] <= s_neg[i];
            end
        end

        assign s_x[i+1]   = r_x[i];
        assign s_y[i+1]   = r_y[i];
        assign s_t[i+1]   = r_t[i];
        assign s_neg[i+1] = r_neg[i];
        assign s_vld[i+1] = r_vld[i];
    end

    assign o_sin = s_neg[N] ? -s_y[N] : s_y[N];
    assign o_cos = s_neg[N] ? -s_x[N] : s_x[N];
    assign o_vld = s_vld[N];

endmodule

// File: rtl/gcd_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module gcd_isqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_vld,
    input  logic [gcd_pkg::SQ_W-1:0]        i_val,
    output logic                            o_vld,
    output logic [gcd_pkg::Q30_W-1:0]       o_root
);
    localparam int N = gcd_pkg::SQRT_STEPS;
    localparam int W = gcd_pkg::SQ_W;

    logic [W-1:0] s_n [0:N];
    logic [W-1:0] s_r [0:N];
    logic         s_vld [0:N];
    logic [W-1:0] r_n [0:N-1];
    logic [W-1:0] r_r [0:N-1];
    logic         r_vld [0:N-1];

    assign s_n[0]   = i_val;
    assign s_r[0]   = '0;
    assign s_vld[0] = i_vld;

    for (genvar k = 0; k < N; k++) begin : g_step
        localparam logic [W-1:0] BIT = W'(1) << (W - 1 - 2*k);
        logic [W:0] n_sum;
        logic       n_ge;

        always_comb begin
            n_sum = {1'b0, s_r[k]} + {1'b0, BIT};
            n_ge  = ({1'b0, s_n[k]} >= n_sum);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (n_ge) begin
                    r_n[k] <= s_n[k] - n_sum[W-1:0];
                    r_r[k] <= (s_r[k] >> 1) + BIT;
                end else begin
                    r_n[k] <= s_n[k];
                    r_r[k] <= s_r[k] >> 1;
                end
            end
        end

        assign s_n[k+1]   = r_n[k];
        assign s_r[k+1]   = r_r[k];
        assign s_vld[k+1] = r_vld[k];
    end

    assign o_root = s_r[N][gcd_pkg::Q30_W-1:0];
    assign o_vld  = s_vld[N];

endmodule

// File: rtl/gcd_cordic_vec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_cordic_vec
// Vectoring-mode CORDIC giving atan2(y, x) in turn units, clamped to a
// quarter turn.
// ----------------------------------------------------------------------------
module gcd_cordic_vec (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_vld,
    input  logic [gcd_pkg::Q30_W-1:0]       i_x,
    input  logic [gcd_pkg::Q30_W-1:0]       i_y,
    output logic                            o_vld,
    output logic [gcd_pkg::Q30_W-1:0]       o_angle
);
    localparam int N = gcd_pkg::CORDIC_ITERATIONS;
    localparam int W = gcd_pkg::XY_W;

    logic signed [W-1:0] s_x [0:N];
    logic signed [W-1:0] s_y [0:N];
    logic signed [W-1:0] s_z [0:N];
    logic                s_vld [0:N];
    logic signed [W-1:0] r_x [0:N-1];
    logic signed [W-1:0] r_y [0:N-1];
    logic signed [W-1:0] r_z [0:N-1];
    logic                r_vld [0:N-1];

    assign s_x[0]   = W'($signed({1'b0, i_x}));
    assign s_y[0]   = W'($signed({1'b0, i_y}));
    assign s_z[0]   = '0;
    assign s_vld[0] = i_vld;

    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [W-1:0] n_dx;
        logic signed [W-1:0] n_dy;
        logic signed [W-1:0] n_at;

        always_comb begin
            n_dx = s_y[i] >>> i;
            n_dy = s_x[i] >>> i;
            n_at = W'(gcd_pkg::ATAN_TURN[i]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_adv) begin
                r_vld[i] <= s_vld[i];
            end
        end

        // Drive y toward zero while summing the rotation angle.
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (s_y[i] > 0) begin
                    r_x[i] <= s_x[i] + n_dx;
                    r_y[i] <= s_y[i] - n_dy;
                    r_z[i] <= s_z[i] + n_at;
                end else begin
                    r_x[i] <= s_x[i] - n_dx;
                    r_y[i] <= s_y[i] + n_dy;
                    r_z[i] <= s_z[i] - n_at;
                end
            end
        end

        assign s_x[i+1]   = r_x[i];
        assign s_y[i+1]   = r_y[i];
        assign s_z[i+1]   = r_z[i];
        assign s_vld[i+1] = r_vld[i];
    end

    // Clamp to the range from zero to a quarter turn.
    always_comb begin
        if (s_z[N] < 0) begin
            o_angle = '0;
        end else if (s_z[N] > gcd_pkg::ONE_Q30) begin
            o_angle = gcd_pkg::ONE_Q30[gcd_pkg::Q30_W-1:0];
        end else begin
            o_angle = s_z[N][gcd_pkg::Q30_W-1:0];
        end
    end

    assign o_vld = s_vld[N];

endmodule

// File: dv/tb_great_circle_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_great_circle_distance
// Self-checking bench for the haversine distance pipeline. A directed table
// covers coordinate extremes, saturation and radius settings. Random point
// pairs then run under several radii. Words are checked against a bit-true
// fixed-point predictor or typed zeros, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_great_circle_distance;

    localparam int  LAT_W        = gcd_pkg::LAT_W;
    localparam int  LNG_W        = gcd_pkg::LNG_W;
    localparam int  RAD_W        = gcd_pkg::RAD_W;
    localparam int  RESET_CYCLES = 12;
    localparam int  PIPE_DRAIN   = 2 * gcd_pkg::CORDIC_ITERATIONS + 100;
    localparam int  STALL_LIMIT  = 20000;
    localparam int  RANDOM_ITEMS = 1700;
    localparam longint ONE       = 64'sd1073741824;

    typedef enum logic {ROW_POINTS, ROW_RADIUS} t_row_kind;

    typedef struct {
        logic signed [LAT_W-1:0] a_lat;
        logic signed [LNG_W-1:0] a_lng;
        logic signed [LAT_W-1:0] b_lat;
        logic signed [LNG_W-1:0] b_lng;
    } t_point_pair;

    typedef struct {
        t_row_kind        kind;
        t_point_pair      pair;
        logic [RAD_W-1:0] radius;
        bit               typed;
        logic [31:0]      distance;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [RAD_W-1:0] i_cfg_wr_data;

    gcd_pt_if   pt_bus ();
    gcd_dist_if dist_bus ();

    great_circle_distance uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pt          (pt_bus.sink),
        .o_dist        (dist_bus.source)
    );

    logic [31:0]      distance_q[$];
    logic [RAD_W-1:0] model_radius;
    int               fail_count;
    int               quiet_cycles;
    bit               idle_on;

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // Fixed-point predictor.
    // ------------------------------------------------------------------
    function automatic longint clamp64(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [31:0] phase_of(longint d, int sh);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? -d : d;
        q = ((mag << sh) + 64'd18000000) / 64'd36000000;
        if (d < 0)
            q = 64'd0 - q;
        return q[31:0];
    endfunction

    task automatic rotate(input logic [31:0] ph, output longint sn, output longint cs);
        longint t;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        t = longint'({32'd0, ph});
        x = 652032874;
        y = 0;
        flip = 0;
        if (t >= (64'sd1 << 31))
            t -= (64'sd1 << 32);
        // Fold into the right half-plane and negate at the end.
        if (t > (64'sd1 << 30)) begin
            t -= (64'sd1 << 31);
            flip = 1;
        end else if (t < -(64'sd1 << 30)) begin
            t += (64'sd1 << 31);
            flip = 1;
        end
        for (int i = 0; i < gcd_pkg::CORDIC_ITERATIONS && i < gcd_pkg::TABLE_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (t >= 0) begin
                x -= dx;
                y += dy;
                t -= longint'(gcd_pkg::ATAN_TURN[i]);
            end else begin
                x += dx;
                y -= dy;
                t += longint'(gcd_pkg::ATAN_TURN[i]);
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    function automatic longint q30_product(longint a, longint b);
        return (a * b + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 60;
        for (int k = 0; k < gcd_pkg::SQRT_STEPS; k++) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint half_central(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < gcd_pkg::CORDIC_ITERATIONS && i < gcd_pkg::TABLE_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx;
                y -= dy;
                z += longint'(gcd_pkg::ATAN_TURN[i]);
            end else begin
                x -= dx;
                y += dy;
                z -= longint'(gcd_pkg::ATAN_TURN[i]);
            end
        end
        return clamp64(z, 0, ONE);
    endfunction

    task automatic predict_distance(input t_point_pair pp, output logic [31:0] cm_out);
        longint lat_a;
        longint lng_a;
        longint lat_b;
        longint lng_b;
        longint s;
        longint c;
        longint ca;
        longint cb;
        longint lat_h;
        longint lng_h;
        longint h;
        longint z;
        longint unsigned p;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned cm;
        lat_a = clamp64(longint'(pp.a_lat), -9000000, 9000000);
        lng_a = clamp64(longint'(pp.a_lng), -18000000, 18000000);
        lat_b = clamp64(longint'(pp.b_lat), -9000000, 9000000);
        lng_b = clamp64(longint'(pp.b_lng), -18000000, 18000000);
        rotate(phase_of(lat_a - lat_b, 31), s, c);
        lat_h = q30_product(s, s);
        rotate(phase_of(lng_a - lng_b, 31), s, c);
        lng_h = q30_product(s, s);
        rotate(phase_of(lat_a, 32), s, ca);
        rotate(phase_of(lat_b, 32), s, cb);
        // Clamp h so that the arcsine argument never exceeds one.
        h = clamp64(lat_h + q30_product(q30_product(ca, cb), lng_h), 0, ONE);
        z = half_central(longint'(int_root(longint'(ONE - h) << 30)),
                         longint'(int_root(longint'(h) << 30)));
        p = longint'(model_radius) * z;
        lo = (p & 64'hFFFF_FFFF) * 64'd1349303771;
        hi = (p >> 32) * 64'd1349303771 + (lo >> 32);
        cm = (hi + (64'd1 << 29)) >> 30;
        cm_out = (cm > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cm[31:0];
    endtask

    // ------------------------------------------------------------------
    // Reporting, output side and watchdog.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Random backpressure on the distance channel.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            dist_bus.ready <= 1'b0;
        else
            dist_bus.ready <= !idle_on || ($urandom_range(99) >= 30);
    end

    // Each accepted distance word is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && dist_bus.valid && dist_bus.ready) begin
            if (distance_q.size() == 0)
                report_mismatch("unexpected word", dist_bus.distance_cm, 32'd0);
            else if (dist_bus.distance_cm !== distance_q[0])
                report_mismatch("distance_cm", dist_bus.distance_cm, distance_q.pop_front());
            else
                void'(distance_q.pop_front());
        end
    end

    // Watchdog on cycles where neither channel moves a word.
    always @(posedge i_clk) begin
        if ((pt_bus.valid && pt_bus.ready) || (dist_bus.valid && dist_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT after %0d quiet cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic send_pair(input t_point_pair pp, input bit typed, input logic [31:0] want);
        logic [31:0] cm;
        if (idle_on && $urandom_range(99) < 30) begin
            pt_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        pt_bus.valid       <= 1'b1;
        pt_bus.point_a_lat <= pp.a_lat;
        pt_bus.point_a_lng <= pp.a_lng;
        pt_bus.point_b_lat <= pp.b_lat;
        pt_bus.point_b_lng <= pp.b_lng;
        do @(posedge i_clk); while (!pt_bus.ready);
        if (typed) begin
            distance_q.push_back(want);
        end else begin
            predict_distance(pp, cm);
            distance_q.push_back(cm);
        end
    endtask

    // Drain the pipeline, then write the radius.
    task automatic set_radius(input logic [RAD_W-1:0] r);
        pt_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (distance_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= r;
        @(posedge i_clk);
        i_cfg_wr_en  <= 1'b0;
        model_radius = r;
    endtask

    function automatic t_point_pair pair_of(int al, int ag, int bl, int bg);
        t_point_pair pp;
        pp.a_lat = LAT_W'(al);
        pp.a_lng = LNG_W'(ag);
        pp.b_lat = LAT_W'(bl);
        pp.b_lng = LNG_W'(bg);
        return pp;
    endfunction

    function automatic t_stim_row pts(int al, int ag, int bl, int bg);
        t_stim_row r;
        r.kind = ROW_POINTS;
        r.pair = pair_of(al, ag, bl, bg);
        r.radius = '0;
        r.typed = 0;
        r.distance = '0;
        return r;
    endfunction

    function automatic t_stim_row pts_zero(int al, int ag, int bl, int bg);
        t_stim_row r;
        r = pts(al, ag, bl, bg);
        r.typed = 1;
        return r;
    endfunction

    function automatic t_stim_row rad(logic [RAD_W-1:0] v);
        t_stim_row r;
        r = pts(0, 0, 0, 0);
        r.kind = ROW_RADIUS;
        r.radius = v;
        return r;
    endfunction

    // Random pair: mostly in range, some near-equal or near-antipodal, some raw bits.
    function automatic t_point_pair random_pair();
        t_point_pair pp;
        int mode;
        mode = $urandom_range(99);
        if (mode < 10) begin
            pp.a_lat = LAT_W'($urandom());
            pp.a_lng = LNG_W'($urandom());
            pp.b_lat = LAT_W'($urandom());
            pp.b_lng = LNG_W'($urandom());
        end else begin
            pp.a_lat = LAT_W'(int'($urandom_range(18000000)) - 9000000);
            pp.a_lng = LNG_W'(int'($urandom_range(36000000)) - 18000000);
            if (mode < 30) begin
                pp.b_lat = LAT_W'(clamp64(longint'(pp.a_lat) + int'($urandom_range(200)) - 100,
                                          -9000000, 9000000));
                pp.b_lng = LNG_W'(clamp64(longint'(pp.a_lng) + int'($urandom_range(200)) - 100,
                                          -18000000, 18000000));
            end else if (mode < 40) begin
                pp.b_lat = LAT_W'(-int'(pp.a_lat) + int'($urandom_range(20)) - 10);
                pp.b_lng = LNG_W'((pp.a_lng >= 0)
                                  ? int'(pp.a_lng) - 18000000 + int'($urandom_range(20))
                                  : int'(pp.a_lng) + 18000000 - int'($urandom_range(20)));
            end else begin
                pp.b_lat = LAT_W'(int'($urandom_range(18000000)) - 9000000);
                pp.b_lng = LNG_W'(int'($urandom_range(36000000)) - 18000000);
            end
        end
        return pp;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        t_stim_row   rows[$];
        logic [RAD_W-1:0] radii[$];
        int          per_phase;

        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        pt_bus.valid       = 1'b0;
        pt_bus.point_a_lat = '0;
        pt_bus.point_a_lng = '0;
        pt_bus.point_b_lat = '0;
        pt_bus.point_b_lng = '0;
        dist_bus.ready     = 1'b0;
        fail_count         = 0;
        quiet_cycles       = 0;
        idle_on            = 1;
        model_radius       = gcd_pkg::RADIUS_RESET;

        // Directed table: reset radius first, then radius extremes.
        rows = '{
            pts(0, 0, 0, 0),
            pts(9000000, 0, -9000000, 0),
            pts(0, 0, 0, 18000000),
            pts(0, -18000000, 0, 18000000),
            pts(4500000, 1000000, 4500001, 1000001),
            pts(-9000000, -18000000, 9000000, 18000000),
            pts(16777215, 33554431, -16777216, -33554432),
            pts(-16777216, -33554432, 9000000, 18000000),
            pts(9000001, 18000001, -9000001, -18000001),
            pts(0, 0, 0, 9000000),
            pts(3000000, -12000000, -6000000, 17999999),
            rad(33'd6000000000),
            pts(0, 0, 0, 18000000),
            pts(9000000, 5, -9000000, 7),
            rad(33'd7000000000),
            pts(0, 0, 0, 18000000),
            pts(-4000000, 100, 4000000, -100),
            rad(33'h1_FFFF_FFFF),
            pts(0, 0, 0, 18000000),
            pts(1, 1, 0, 0),
            rad(33'd0),
            pts_zero(0, 0, 0, 18000000),
            pts_zero(9000000, -18000000, -9000000, 18000000),
            pts_zero(16777215, 33554431, -16777216, -33554432)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_RADIUS)
                set_radius(rows[i].radius);
            else
                send_pair(rows[i].pair, rows[i].typed, rows[i].distance);
        end

        // Random part over several radii, with one stretch free of idling.
        radii = '{gcd_pkg::RADIUS_RESET, 33'd6000000000, 33'd7000000000,
                  33'd6000000000 + RAD_W'($urandom_range(1000000000)),
                  RAD_W'({$urandom_range(1), $urandom()}), 33'h1_FFFF_FFFF};
        per_phase = RANDOM_ITEMS / radii.size();
        foreach (radii[p]) begin
            set_radius(radii[p]);
            for (int n = 0; n < per_phase; n++) begin
                idle_on = !(p == 2 && n >= per_phase / 4 && n < 3 * per_phase / 4);
                send_pair(random_pair(), 0, '0);
            end
            idle_on = 1;
        end
        pt_bus.valid <= 1'b0;

        // Wait for every expected word, then for the pipeline to settle.
        while (distance_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);

        if (fail_count == 0 && distance_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
